// File: hdl/gmf_pkg.sv
`default_nettype none
package gmf_pkg;

  localparam int unsigned MAX_WIDTH_DEF     = 1024;
  localparam int unsigned KERNEL_SIZE_DEF   = 3;
  localparam int unsigned LOG_FRAC_BITS_DEF = 12;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GAIN         = 2'd2;
  localparam logic [1:0] CFG_LEVEL_OFFSET = 2'd3;

  localparam logic [10:0]       WIDTH_RST  = 11'd1024;
  localparam logic [12:0]       HEIGHT_RST = 13'd768;
  localparam logic [15:0]       GAIN_RST   = 16'd256;
  localparam logic signed [8:0] OFFSET_RST = 9'sd0;

  // Channel codes.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [3:0] LAST_TAP = 4'd8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WIN,
    S_SUM,
    S_DIV,
    S_MEAN,
    S_BS,
    S_LOGW,
    S_SCALE,
    S_CLAMP,
    S_OUT
  } gmf_state_e;

  typedef struct packed {
    logic       p_load;
    logic       rd_en;
    logic       wr_en;
    logic       win_upd;
    logic       top_up;
    logic       bot_mid;
    logic       nb_old;
    logic       nb_new;
    logic [1:0] left_idx;
    logic       acc_add;
    logic       acc_first;
    logic [3:0] k;
    logic [1:0] ch;
    logic       div_load;
    logic       mean_load;
    logic       log_start;
    logic       bs_upd;
    logic       scale_load;
    logic       res_load;
    logic       out_load;
    logic       out_fend;
  } gmf_cmd_t;

  typedef struct packed {
    logic zero;
    logic bs_more;
    logic log_done;
  } gmf_status_t;

  // Fixed-point log2 evaluated at elaboration to build the sample table.
  function automatic int unsigned log2_fixed_f(input int unsigned v, input int unsigned lfb);
    int unsigned       vv;
    int unsigned       e;
    int unsigned       frac;
    int unsigned       i;
    longint unsigned   x;
    vv = v & 32'h0000_FFFF;
    if (vv == 0) begin
      return 0;
    end
    e = 0;
    while (e < 15 && (vv >> (e + 1)) != 0) begin
      e = e + 1;
    end
    x = longint'(vv) << (30 - e);
    frac = 0;
    i = 0;
    while (i < lfb) begin
      x = (x * x) >> 30;
      frac = frac << 1;
      if (x >= 64'h0000_0000_8000_0000) begin
        x = x >> 1;
        frac = frac | 1;
      end
      i = i + 1;
    end
    return (e << lfb) | frac;
  endfunction

endpackage
`default_nettype wire

// File: hdl/gmf_log2.sv
`default_nettype none
module gmf_log2 #(
  parameter int unsigned LOG_FRAC_BITS = gmf_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [15:0]                 value_i,
  output logic [4+LOG_FRAC_BITS-1:0]       result_o,
  output logic                             done_o
);
  localparam int unsigned CW = $clog2(LOG_FRAC_BITS + 1);

  logic [30:0]              x_q, x_d;
  logic [3:0]               e_q, e_d;
  logic [LOG_FRAC_BITS-1:0] frac_q, frac_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [3:0]               msb;
  logic [61:0]              sq;
  logic [31:0]              sq_top;

  // Position of the leading one of the operand.
  always_comb begin
    msb = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (value_i[b]) begin
        msb = 4'(b);
      end
    end
  end

  assign sq     = 62'(x_q) * 62'(x_q);
  assign sq_top = sq[61:30];

  always_comb begin
    x_d    = x_q;
    e_d    = e_q;
    frac_d = frac_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      x_d    = 31'({15'd0, value_i} << (5'd30 - 5'(msb)));
      e_d    = msb;
      frac_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // One squaring per cycle yields one fraction bit.
      if (sq_top[31]) begin
        x_d    = sq_top[31:1];
        frac_d = {frac_q[LOG_FRAC_BITS-2:0], 1'b1};
      end else begin
        x_d    = sq_top[30:0];
        frac_d = {frac_q[LOG_FRAC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(LOG_FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    e_q    <= e_d;
    frac_q <= frac_d;
  end

  assign result_o = {e_q, frac_q};
  assign done_o   = done_q;

endmodule
`default_nettype wire

// File: hdl/gmf_datapath.sv
`default_nettype none
module gmf_datapath #(
  parameter int unsigned MAX_WIDTH     = gmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned LOG_FRAC_BITS = gmf_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gmf_pkg::gmf_cmd_t            cmd_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0] addr_i,
  input  wire logic [7:0]                   red_i,
  input  wire logic [7:0]                   green_i,
  input  wire logic [7:0]                   blue_i,
  input  wire logic [15:0]                  gain_i,
  input  wire logic signed [8:0]            offset_i,
  output gmf_pkg::gmf_status_t              status_o,
  output logic [7:0]                        red_o,
  output logic [7:0]                        green_o,
  output logic [7:0]                        blue_o,
  output logic                              fend_o
);
  localparam int unsigned LW        = 4 + LOG_FRAC_BITS;
  localparam int unsigned SW        = LW + 4;
  localparam int unsigned DIV_SHIFT = LW + 7;
  localparam int unsigned MW        = DIV_SHIFT - 3;
  localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'd8) / 64'd9;
  localparam logic [LW:0] EXP_BIAS  = (LW+1)'(8 << LOG_FRAC_BITS);

  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];

  logic [23:0] p_q, up_q, mid_q;
  logic [23:0] win_q [3][3];
  logic [23:0] win_d [3][3];
  logic [23:0] nb_q [9];
  logic [LW-1:0] log_rom [256];

  logic [SW-1:0]    acc_q;
  logic             zero_q;
  logic [SW+MW-1:0] prod_q;
  logic [LW:0]      target_q;
  logic [15:0]      lo_q, hi_q, midv_q, midv;
  logic [31:0]      sprod_q;
  logic [7:0]       res_q [3];
  logic [7:0]       sample;
  logic [23:0]      tap;
  logic [LW-1:0]    log_res;
  logic             log_done;
  logic [15:0]      g;
  logic signed [17:0] lvl;
  logic [7:0]       clamped;

  for (genvar gi = 0; gi < 256; gi++) begin : g_rom
    assign log_rom[gi] = LW'(gmf_pkg::log2_fixed_f(gi, LOG_FRAC_BITS));
  end

  // Line stores: read in the cycle before the write to the same column.
  always_ff @(posedge clk_i) begin
    if (cmd_i.p_load) begin
      p_q <= {red_i, green_i, blue_i};
    end
    if (cmd_i.rd_en) begin
      up_q  <= upper_mem[addr_i];
      mid_q <= middle_mem[addr_i];
    end
    if (cmd_i.wr_en) begin
      upper_mem[addr_i]  <= mid_q;
      middle_mem[addr_i] <= p_q;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = cmd_i.top_up ? up_q : mid_q;
    win_d[1][2] = mid_q;
    win_d[2][2] = cmd_i.bot_mid ? mid_q : p_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cmd_i.win_upd) begin
      win_q <= win_d;
    end
  end

  // Neighborhood snapshot, taken from the window before or after its shift.
  always_ff @(posedge clk_i) begin
    if (cmd_i.nb_old) begin
      for (int r = 0; r < 3; r++) begin
        nb_q[r*3+0] <= win_q[r][cmd_i.left_idx];
        nb_q[r*3+1] <= win_q[r][2];
        nb_q[r*3+2] <= win_q[r][2];
      end
    end else if (cmd_i.nb_new) begin
      for (int r = 0; r < 3; r++) begin
        nb_q[r*3+0] <= win_d[r][cmd_i.left_idx];
        nb_q[r*3+1] <= win_d[r][1];
        nb_q[r*3+2] <= win_d[r][2];
      end
    end
  end

  assign tap = nb_q[cmd_i.k];

  always_comb begin
    case (cmd_i.ch)
      gmf_pkg::CH_RED:   sample = tap[23:16];
      gmf_pkg::CH_GREEN: sample = tap[15:8];
      default:           sample = tap[7:0];
    endcase
  end

  assign midv = 16'(({1'b0, lo_q} + {1'b0, hi_q} + 17'd1) >> 1);
  assign g    = zero_q ? 16'd0 : lo_q;

  always_comb begin
    lvl = $signed({2'b00, sprod_q[31:16]}) + 18'(offset_i);
    if (lvl < 0) begin
      clamped = 8'd0;
    end else if (lvl > 18'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = lvl[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_add) begin
      if (cmd_i.acc_first) begin
        acc_q  <= SW'(log_rom[sample]);
        zero_q <= (sample == 8'd0);
      end else begin
        acc_q  <= acc_q + SW'(log_rom[sample]);
        zero_q <= zero_q | (sample == 8'd0);
      end
    end
    if (cmd_i.div_load) begin
      prod_q <= (SW+MW)'(acc_q) * (SW+MW)'(DIV_MUL);
    end
    if (cmd_i.mean_load) begin
      target_q <= {1'b0, prod_q[DIV_SHIFT +: LW]} + EXP_BIAS;
      lo_q     <= 16'd256;
      hi_q     <= 16'd65535;
    end
    if (cmd_i.log_start) begin
      midv_q <= midv;
    end
    if (cmd_i.bs_upd) begin
      if ({1'b0, log_res} <= target_q) begin
        lo_q <= midv_q;
      end else begin
        hi_q <= midv_q - 16'd1;
      end
    end
    if (cmd_i.scale_load) begin
      sprod_q <= 32'(g) * 32'(gain_i);
    end
    if (cmd_i.res_load) begin
      res_q[cmd_i.ch] <= clamped;
    end
    if (cmd_i.out_load) begin
      red_o   <= res_q[gmf_pkg::CH_RED];
      green_o <= res_q[gmf_pkg::CH_GREEN];
      blue_o  <= res_q[gmf_pkg::CH_BLUE];
      fend_o  <= cmd_i.out_fend;
    end
  end

  gmf_log2 #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.log_start),
    .value_i (midv),
    .result_o(log_res),
    .done_o  (log_done)
  );

  assign status_o.zero     = zero_q;
  assign status_o.bs_more  = (lo_q < hi_q);
  assign status_o.log_done = log_done;

endmodule
`default_nettype wire

// File: hdl/gmf_ctrl.sv
`default_nettype none
module gmf_ctrl #(
  parameter int unsigned MAX_WIDTH = gmf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  input  wire logic [10:0]            width_i,
  input  wire logic [12:0]            height_i,
  input  wire gmf_pkg::gmf_status_t   status_i,
  output gmf_pkg::gmf_cmd_t           cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0] addr_o
);
  localparam int unsigned AW = $clog2(MAX_WIDTH);

  gmf_pkg::gmf_state_e state_q, state_d;

  logic [AW-1:0] col_q, col_d, col_lat_q, col_lat_d;
  logic [13:0]   row_q, row_d;
  logic          top_up_q, top_up_d, bot_mid_q, bot_mid_d;
  logic          emit_new_q, emit_new_d, emit_any_q, emit_any_d;
  logic          fend_q, fend_d;
  logic [1:0]    ch_q, ch_d;
  logic [3:0]    k_q, k_d;
  logic          out_valid_q, out_valid_d;

  logic [12:0] weff, heff, col_next;
  logic        accept, flush, emit_old, emit_new, w_one;

  always_comb begin
    if (width_i == 11'd0) begin
      weff = 13'd1;
    end else if (13'(width_i) > 13'(MAX_WIDTH)) begin
      weff = 13'(MAX_WIDTH);
    end else begin
      weff = 13'(width_i);
    end
  end

  assign heff     = (height_i == 13'd0) ? 13'd1 : height_i;
  assign w_one    = (weff == 13'd1);
  assign col_next = 13'(col_q) + 13'd1;
  assign accept   = in_valid_i && in_ready_o;
  assign flush    = (row_q >= 14'(heff) + 14'd1);
  assign emit_old = flush || (col_q == '0 && row_q >= 14'd2);
  assign emit_new = !flush && (col_q != '0) && (row_q >= 14'd1);

  assign in_ready_o  = (state_q == gmf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign addr_o      = (state_q == gmf_pkg::S_IDLE) ? col_q : col_lat_q;

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    col_lat_d   = col_lat_q;
    top_up_d    = top_up_q;
    bot_mid_d   = bot_mid_q;
    emit_new_d  = emit_new_q;
    emit_any_d  = emit_any_q;
    fend_d      = fend_q;
    ch_d        = ch_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.k     = k_q;
    cmd_o.ch    = ch_q;
    cmd_o.top_up   = top_up_q;
    cmd_o.bot_mid  = bot_mid_q;
    cmd_o.out_fend = fend_q;

    case (state_q)
      gmf_pkg::S_IDLE: begin
        cmd_o.left_idx = w_one ? 2'd2 : 2'd1;
        if (accept) begin
          cmd_o.p_load = 1'b1;
          cmd_o.nb_old = emit_old;
          col_lat_d    = col_q;
          top_up_d     = (row_q >= 14'd2);
          bot_mid_d    = (row_q >= 14'(heff));
          emit_new_d   = emit_new;
          emit_any_d   = emit_old || emit_new;
          fend_d       = flush;
          if (flush) begin
            col_d   = '0;
            row_d   = '0;
            state_d = gmf_pkg::S_SUM;
          end else begin
            cmd_o.rd_en = 1'b1;
            if (col_next >= weff) begin
              col_d = '0;
              row_d = row_q + 14'd1;
            end else begin
              col_d = AW'(col_next);
            end
            state_d = gmf_pkg::S_WIN;
          end
        end
      end
      gmf_pkg::S_WIN: begin
        cmd_o.win_upd  = 1'b1;
        cmd_o.wr_en    = !bot_mid_q;
        cmd_o.nb_new   = emit_new_q;
        cmd_o.left_idx = (col_lat_q == AW'(1)) ? 2'd1 : 2'd0;
        state_d        = emit_any_q ? gmf_pkg::S_SUM : gmf_pkg::S_IDLE;
      end
      gmf_pkg::S_SUM: begin
        cmd_o.acc_add   = 1'b1;
        cmd_o.acc_first = (k_q == 4'd0);
        if (k_q == gmf_pkg::LAST_TAP) begin
          k_d     = 4'd0;
          state_d = gmf_pkg::S_DIV;
        end else begin
          k_d = k_q + 4'd1;
        end
      end
      gmf_pkg::S_DIV: begin
        cmd_o.div_load = 1'b1;
        state_d        = gmf_pkg::S_MEAN;
      end
      gmf_pkg::S_MEAN: begin
        cmd_o.mean_load = 1'b1;
        state_d         = status_i.zero ? gmf_pkg::S_SCALE : gmf_pkg::S_BS;
      end
      gmf_pkg::S_BS: begin
        if (status_i.bs_more) begin
          cmd_o.log_start = 1'b1;
          state_d         = gmf_pkg::S_LOGW;
        end else begin
          state_d = gmf_pkg::S_SCALE;
        end
      end
      gmf_pkg::S_LOGW: begin
        if (status_i.log_done) begin
          cmd_o.bs_upd = 1'b1;
          state_d      = gmf_pkg::S_BS;
        end
      end
      gmf_pkg::S_SCALE: begin
        cmd_o.scale_load = 1'b1;
        state_d          = gmf_pkg::S_CLAMP;
      end
      gmf_pkg::S_CLAMP: begin
        cmd_o.res_load = 1'b1;
        if (ch_q == gmf_pkg::CH_BLUE) begin
          ch_d    = gmf_pkg::CH_RED;
          state_d = gmf_pkg::S_OUT;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = gmf_pkg::S_SUM;
        end
      end
      gmf_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = gmf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gmf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gmf_pkg::S_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      ch_q        <= gmf_pkg::CH_RED;
      k_q         <= 4'd0;
      out_valid_q <= 1'b0;
      emit_new_q  <= 1'b0;
      emit_any_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ch_q        <= ch_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      emit_new_q  <= emit_new_d;
      emit_any_q  <= emit_any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_lat_q <= col_lat_d;
    top_up_q  <= top_up_d;
    bot_mid_q <= bot_mid_d;
    fend_q    <= fend_d;
  end

endmodule
`default_nettype wire

// File: hdl/geometric_mean_filter_3x3.sv
`default_nettype none
// Streaming 3x3 geometric-mean filter for 8-bit RGB pixels in raster order. Each result word
// holds, per channel, exp2 of the mean of log2 over the 3x3 neighborhood with replicated
// edges, scaled by gain_q8_8, offset by level_offset and clamped to 0..255; a zero sample
// forces that channel's mean to zero. Results lag the input by one line and one pixel, so
// every frame must be followed by image_width + 1 flush words (is_padding is carried for
// the source's benefit; the position counters alone decide what is flush). Per channel the nine
// logs are summed from a table one tap per cycle, and the exp2 is a binary search of up to 16
// probes whose every probe runs the shared log2 unit, one squaring multiply per fraction bit.
// The block takes a new word while a finished result still waits in the output register. The
// line stores hold no reset state and need no clearing pass; configuration is written through
// a plain write port, which the user must use only while idle; the block does not enforce it.
module geometric_mean_filter_3x3 #(
  parameter int unsigned MAX_WIDTH     = gmf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned LOG_FRAC_BITS = gmf_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  red_in_i,
  input  wire logic [7:0]  green_in_i,
  input  wire logic [7:0]  blue_in_i,
  input  wire logic        is_padding_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       red_out_o,
  output logic [7:0]       green_out_o,
  output logic [7:0]       blue_out_o,
  output logic             frame_end_o
);

  // Configuration registers.
  logic [10:0]       width_q;
  logic [12:0]       height_q;
  logic [15:0]       gain_q;
  logic signed [8:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gmf_pkg::WIDTH_RST;
      height_q <= gmf_pkg::HEIGHT_RST;
      gain_q   <= gmf_pkg::GAIN_RST;
      offset_q <= gmf_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gmf_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[10:0];
        gmf_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i[12:0];
        gmf_pkg::CFG_GAIN:         gain_q   <= cfg_data_i;
        gmf_pkg::CFG_LEVEL_OFFSET: offset_q <= $signed(cfg_data_i[8:0]);
        default: ;
      endcase
    end
  end

  gmf_pkg::gmf_cmd_t            cmd;
  gmf_pkg::gmf_status_t         status;
  logic [$clog2(MAX_WIDTH)-1:0] addr;

  // The controller owns the position counters and the sequencing of each word.
  gmf_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .status_i   (status),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  // The datapath holds the line stores, the window and the arithmetic.
  gmf_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_datapath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .addr_i  (addr),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .gain_i  (gain_q),
    .offset_i(offset_q),
    .status_o(status),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o),
    .fend_o  (frame_end_o)
  );

  // The flush flag is informational only.
  logic padding_seen;
  assign padding_seen = is_padding_i & in_valid_i;

  // A word is taken only when the controller is idle, so it cannot accept twice in a row.
  a_one_word_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !padding_seen |=> !in_ready_o)
    else $error("input accepted on consecutive cycles");

  // A new result must never overwrite one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // Starting the log2 unit clears its done flag on the next cycle.
  a_log_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.log_start |=> !status.log_done)
    else $error("log2 unit reported done right after start");

endmodule
`default_nettype wire

// File: sim/geometric_mean_filter_3x3_test.sv
`default_nettype none
module geometric_mean_filter_3x3_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX  = 1024;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CYCLE_CAP = 8_000_000;
  localparam int unsigned SETTLE    = 50;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pad;
  } pixel_word_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fend;
  } filtered_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = gmf_pkg::CFG_IMAGE_WIDTH;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  red_in_i = '0;
  logic [7:0]  green_in_i = '0;
  logic [7:0]  blue_in_i = '0;
  logic        is_padding_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;
  logic        frame_end_o;

  geometric_mean_filter_3x3 dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .red_in_i, .green_in_i, .blue_in_i, .is_padding_i,
    .out_valid_o, .out_ready_i, .red_out_o, .green_out_o, .blue_out_o, .frame_end_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Words waiting to be sent, and filtered words the block still owes us.
  pixel_word_t    pending_pixels[$];
  filtered_word_t owed_pixels[$];
  pixel_word_t    next_pixel;

  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 59;
  int unsigned words_taken = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Shadow of the configuration registers as the predictor sees them.
  logic [10:0]       shadow_width  = gmf_pkg::WIDTH_RST;
  logic [12:0]       shadow_height = gmf_pkg::HEIGHT_RST;
  logic [15:0]       shadow_gain   = gmf_pkg::GAIN_RST;
  logic signed [8:0] shadow_offset = gmf_pkg::OFFSET_RST;

  // Predictor state: two line buffers, the 3x3 window and the raster position.
  logic [23:0]  line_above[LINE_MAX];
  logic [23:0]  line_mid[LINE_MAX];
  logic [23:0]  window[3][3];
  int unsigned  col_pos = 0;
  int unsigned  row_pos = 0;

  // log2 of every 16-bit value, with twelve fraction bits.
  int unsigned  log_lut[65536];

  // Fixed-point log2: the integer part is the top set bit, and each fraction bit
  // comes from squaring the normalized mantissa and checking whether it reached 2.
  function automatic int unsigned fixed_log2(input int unsigned v);
    int unsigned     top;
    int unsigned     frac;
    longint unsigned m;
    top = 0;
    frac = 0;
    if (v == 0) return 0;
    while (top < 15 && (v >> (top + 1)) != 0) top++;
    m = longint'(v) << (30 - top);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (top << FRAC_BITS) | frac;
  endfunction

  // Geometric mean of one channel of the window, then gain, offset and clamp.
  function automatic logic [7:0] filter_channel(input logic [23:0] taps[9],
                                               input int unsigned shift);
    int unsigned log_sum;
    int unsigned target;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    bit          has_zero;
    longint      level;
    logic [7:0]  s;
    log_sum = 0;
    has_zero = 1'b0;
    for (int k = 0; k < 9; k++) begin
      s = 8'(taps[k] >> shift);
      if (s == 0) has_zero = 1'b1;
      log_sum += log_lut[s];
    end
    lo = 0;
    if (!has_zero) begin
      // Largest Q8.8 value whose log2 (less 8) does not exceed the mean log.
      target = log_sum / 9 + (8 << FRAC_BITS);
      lo = 256;
      hi = 65535;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (log_lut[mid] <= target) lo = mid;
        else hi = mid - 1;
      end
    end
    level = longint'((longint'(lo) * longint'(shadow_gain)) >>> 16) + longint'(shadow_offset);
    if (level < 0) level = 0;
    if (level > 255) level = 255;
    return level[7:0];
  endfunction

  task automatic owe_pixel(input int left, input int center, input int right,
                           input logic fend);
    logic [23:0]    taps[9];
    filtered_word_t fw;
    for (int r = 0; r < 3; r++) begin
      taps[r * 3 + 0] = window[r][left];
      taps[r * 3 + 1] = window[r][center];
      taps[r * 3 + 2] = window[r][right];
    end
    fw.red   = filter_channel(taps, 16);
    fw.green = filter_channel(taps, 8);
    fw.blue  = filter_channel(taps, 0);
    fw.fend  = fend;
    owed_pixels.push_back(fw);
  endtask

  // Advance the predictor by one accepted word.
  task automatic take_pixel(input pixel_word_t pw);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [23:0] p;
    logic [23:0] top;
    logic [23:0] bot;
    w = (shadow_width == 0) ? 1 : (shadow_width > LINE_MAX ? LINE_MAX : shadow_width);
    h = (shadow_height == 0) ? 1 : shadow_height;
    c = (col_pos >= LINE_MAX) ? LINE_MAX - 1 : col_pos;
    r = row_pos;
    if (r >= h + 1) begin
      // The lone word after the flush row releases the bottom-right pixel.
      owe_pixel((w == 1) ? 2 : 1, 2, 2, 1'b1);
      col_pos = 0;
      row_pos = 0;
      return;
    end
    // The first word of a line finishes the last pixel of the line two above.
    if (c == 0 && r >= 2) owe_pixel((w == 1) ? 2 : 1, 2, 2, 1'b0);
    p = {pw.red, pw.green, pw.blue};
    top = (r >= 2) ? line_above[c] : line_mid[c];
    bot = (r >= h) ? line_mid[c] : p;
    for (int k = 0; k < 3; k++) begin
      window[k][0] = window[k][1];
      window[k][1] = window[k][2];
    end
    window[0][2] = top;
    window[1][2] = line_mid[c];
    window[2][2] = bot;
    if (r < h) begin
      line_above[c] = line_mid[c];
      line_mid[c] = p;
    end
    if (c >= 1 && r >= 1) owe_pixel((c == 1) ? 1 : 0, 1, 2, 1'b0);
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Driver: a word stays on the bus until it is accepted; a new one is offered
  // only when the bus is free, so valid never drops while a word is waiting.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        take_pixel('{red_in_i, green_in_i, blue_in_i, is_padding_i});
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_pixel = pending_pixels.pop_front();
          in_valid_i   <= 1'b1;
          red_in_i     <= next_pixel.red;
          green_in_i   <= next_pixel.green;
          blue_in_i    <= next_pixel.blue;
          is_padding_i <= next_pixel.pad;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: every accepted result is checked against the oldest owed word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_pixels.size() == 0) begin
        $display("%0t: unexpected result r=%0d g=%0d b=%0d fend=%0d", $realtime,
                 red_out_o, green_out_o, blue_out_o, frame_end_o);
        fail_count++;
      end else begin
        if (red_out_o !== owed_pixels[0].red) begin
          $display("%0t: red expected %0d actual %0d", $realtime,
                   owed_pixels[0].red, red_out_o);
          fail_count++;
        end
        if (green_out_o !== owed_pixels[0].green) begin
          $display("%0t: green expected %0d actual %0d", $realtime,
                   owed_pixels[0].green, green_out_o);
          fail_count++;
        end
        if (blue_out_o !== owed_pixels[0].blue) begin
          $display("%0t: blue expected %0d actual %0d", $realtime,
                   owed_pixels[0].blue, blue_out_o);
          fail_count++;
        end
        if (frame_end_o !== owed_pixels[0].fend) begin
          $display("%0t: frame_end expected %0d actual %0d", $realtime,
                   owed_pixels[0].fend, frame_end_o);
          fail_count++;
        end
        void'(owed_pixels.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("geometric_mean_filter_3x3 verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gmf_pkg::CFG_IMAGE_WIDTH:  shadow_width  = value[10:0];
      gmf_pkg::CFG_IMAGE_HEIGHT: shadow_height = value[12:0];
      gmf_pkg::CFG_GAIN:         shadow_gain   = value;
      gmf_pkg::CFG_LEVEL_OFFSET: shadow_offset = value[8:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_sample(input int unsigned style);
    case (style)
      0: return 8'($urandom);
      1: return ($urandom_range(5) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
      2: return 8'($urandom_range(255, 240));
      default: return 8'($urandom_range(4));
    endcase
  endfunction

  // Program one frame geometry and levels, queue the frame and its flush words,
  // then wait until the block has delivered everything and gone quiet.
  task automatic run_frame(input logic [15:0] w_reg, input logic [15:0] h_reg,
                           input logic [15:0] gain, input logic [15:0] offset,
                           input int unsigned style);
    int unsigned w;
    int unsigned h;
    pixel_word_t pw;
    write_reg(gmf_pkg::CFG_IMAGE_WIDTH, w_reg);
    write_reg(gmf_pkg::CFG_IMAGE_HEIGHT, h_reg);
    write_reg(gmf_pkg::CFG_GAIN, gain);
    write_reg(gmf_pkg::CFG_LEVEL_OFFSET, offset);
    w = (w_reg[10:0] == 0) ? 1 : (w_reg[10:0] > LINE_MAX ? LINE_MAX : w_reg[10:0]);
    h = (h_reg[12:0] == 0) ? 1 : h_reg[12:0];
    for (int i = 0; i < w * h; i++) begin
      pw.red   = pick_sample(style);
      pw.green = pick_sample(style);
      pw.blue  = pick_sample(style);
      pw.pad   = 1'b0;
      pending_pixels.push_back(pw);
    end
    // Flush words carry junk samples; only their position matters.
    for (int i = 0; i < w + 1; i++) begin
      pw.red   = 8'($urandom);
      pw.green = 8'($urandom);
      pw.blue  = 8'($urandom);
      pw.pad   = 1'b1;
      pending_pixels.push_back(pw);
    end
    while (pending_pixels.size() != 0 || in_valid_i || owed_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int unsigned total_words;
    for (int v = 0; v < 65536; v++) log_lut[v] = fixed_log2(v);
    for (int i = 0; i < LINE_MAX; i++) begin
      line_above[i] = '0;
      line_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) window[r][c] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: single pixel, zero and full-scale samples, gain and
    // offset extremes, a zero height register and register writes whose
    // upper bits lie outside the fields.
    run_frame(16'd1, 16'd1, 16'd256, 16'd0, 0);
    run_frame(16'd2, 16'd2, 16'hFFFF, 16'h0101, 1);
    run_frame(16'd3, 16'd0, 16'd0, 16'h00FF, 2);
    run_frame(16'd1, 16'd3, 16'd300, 16'h0000, 3);
    run_frame(16'd3, 16'd2, 16'd256, 16'h01F6, 1);
    run_frame(16'hF805, 16'h2002, 16'd256, 16'hFE00, 0);

    // Random frames, mostly small, through three idling phases.
    total_words = 0;
    while (total_words < 1100) begin
      int unsigned w;
      int unsigned h;
      if (total_words >= 733) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (total_words >= 366) begin
        send_idle_pct = 59;
        recv_idle_pct = 27;
      end
      w = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
      h = $urandom_range(5, 1);
      total_words += w * h + w + 1;
      run_frame(16'(w), 16'(h), 16'($urandom_range(65535)),
                16'($urandom_range(510) - 255) & 16'h01FF, $urandom_range(3));
    end

    if (fail_count == 0) begin
      $display("geometric_mean_filter_3x3 verification clean");
    end else begin
      $display("geometric_mean_filter_3x3 verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
